// ===== src/dqcd_pkg.sv =====
// Package for the DQPSK carrier demodulator: widths, item codes and the
// control structs passed between the datapath, the slicer and the output FIFO.
// No dependencies.
`default_nettype none

package dqcd_pkg;

    localparam int SAMP_W     = 16;
    localparam int PROD_W     = 33;
    localparam int MAG_W      = 32;
    localparam int SQ_W       = 64;
    localparam int ACC_W      = 80;
    localparam int Q_W        = 7;
    localparam int SOFT_W     = 8;
    localparam int FIFO_DEPTH = 16;

    localparam logic KIND_REF  = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    typedef struct packed {
        logic valid;
        logic last;
        logic neg_i;
        logic zero_i;
        logic neg_q;
        logic zero_q;
    } slice_ctrl_t;

    typedef struct packed {
        logic valid;
        logic last;
    } res_ctrl_t;

endpackage

`default_nettype wire

// ===== src/dqcd_phase_mem.sv =====
// Per-bin phase reference memory, one synchronous port, read before write.
// Depends on nothing.
`default_nettype none

module dqcd_phase_mem #(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              en,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [0:DEPTH-1];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata_reg  <= mem[addr];
            mem[addr]  <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/dqcd_soft_slicer.sv =====
// Soft-bit slicer: finds the largest q with q*q*(c*c+o*o) <= 127*127*c*c
// one bit per pipeline stage, for both lanes. Depends on dqcd_pkg.
`default_nettype none

module dqcd_soft_slicer import dqcd_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  slice_ctrl_t              ctrl,
    input  logic [SQ_W-1:0]          sq_i,
    input  logic [SQ_W-1:0]          sq_q,
    output res_ctrl_t                res,
    output logic signed [SOFT_W-1:0] soft_i,
    output logic signed [SOFT_W-1:0] soft_q
);

    localparam int STEPS = Q_W;

    slice_ctrl_t             ctrl_reg [0:STEPS];
    logic [ACC_W-1:0]        m_reg    [0:STEPS];
    logic [ACC_W-1:0]        t_reg    [0:STEPS][0:1];
    logic [ACC_W-1:0]        p_reg    [0:STEPS][0:1];
    logic [ACC_W-1:0]        qm_reg   [0:STEPS][0:1];
    logic [Q_W-1:0]          q_reg    [0:STEPS][0:1];
    logic [ACC_W-1:0]        trial    [0:STEPS-1][0:1];
    logic                    take     [0:STEPS-1][0:1];
    logic [ACC_W-1:0]        ci_ext;
    logic [ACC_W-1:0]        cq_ext;
    res_ctrl_t               res_reg;
    logic signed [SOFT_W-1:0] soft_i_reg;
    logic signed [SOFT_W-1:0] soft_q_reg;
    logic signed [SOFT_W-1:0] mag_i;
    logic signed [SOFT_W-1:0] mag_q;

    assign ci_ext = ACC_W'(sq_i);
    assign cq_ext = ACC_W'(sq_q);

    // Each stage tries the next lower bit of q, with the running values
    // p = q*q*m and qm = q*m kept so that the trial is only adds and shifts.
    always_comb
    begin
        for (int s = 0; s < STEPS; s++)
        begin
            for (int l = 0; l < 2; l++)
            begin
                trial[s][l] = p_reg[s][l] + (qm_reg[s][l] << (STEPS - s))
                            + (m_reg[s] << (2 * (STEPS - 1 - s)));
                take[s][l]  = (trial[s][l] <= t_reg[s][l]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg[0] <= ci_ext + cq_ext;
        // 127*127 = 2^14 - 2^8 + 1.
        t_reg[0][0] <= (ci_ext << 14) - (ci_ext << 8) + ci_ext;
        t_reg[0][1] <= (cq_ext << 14) - (cq_ext << 8) + cq_ext;
        for (int l = 0; l < 2; l++)
        begin
            p_reg[0][l]  <= '0;
            qm_reg[0][l] <= '0;
            q_reg[0][l]  <= '0;
        end
        for (int s = 0; s < STEPS; s++)
        begin
            m_reg[s+1] <= m_reg[s];
            for (int l = 0; l < 2; l++)
            begin
                t_reg[s+1][l] <= t_reg[s][l];
                if (take[s][l])
                begin
                    p_reg[s+1][l]  <= trial[s][l];
                    qm_reg[s+1][l] <= qm_reg[s][l] + (m_reg[s] << (STEPS - 1 - s));
                    q_reg[s+1][l]  <= q_reg[s][l] | (Q_W'(1) << (STEPS - 1 - s));
                end
                else
                begin
                    p_reg[s+1][l]  <= p_reg[s][l];
                    qm_reg[s+1][l] <= qm_reg[s][l];
                    q_reg[s+1][l]  <= q_reg[s][l];
                end
            end
        end
        soft_i_reg <= ctrl_reg[STEPS].zero_i ? '0 :
                      (ctrl_reg[STEPS].neg_i ? -mag_i : mag_i);
        soft_q_reg <= ctrl_reg[STEPS].zero_q ? '0 :
                      (ctrl_reg[STEPS].neg_q ? -mag_q : mag_q);
    end

    assign mag_i = SOFT_W'({1'b0, q_reg[STEPS][0]});
    assign mag_q = SOFT_W'({1'b0, q_reg[STEPS][1]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= STEPS; s++)
            begin
                ctrl_reg[s] <= '0;
            end
            res_reg <= '0;
        end
        else
        begin
            ctrl_reg[0] <= ctrl;
            for (int s = 0; s < STEPS; s++)
            begin
                ctrl_reg[s+1] <= ctrl_reg[s];
            end
            res_reg.valid <= ctrl_reg[STEPS].valid;
            res_reg.last  <= ctrl_reg[STEPS].last;
        end
    end

    assign res    = res_reg;
    assign soft_i = soft_i_reg;
    assign soft_q = soft_q_reg;

endmodule

`default_nettype wire

// ===== src/dqcd_out_fifo.sv =====
// Output FIFO that holds finished soft-bit results until the receiver takes them.
// Depends on dqcd_pkg.
`default_nettype none

module dqcd_out_fifo import dqcd_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  res_ctrl_t                wr,
    input  logic signed [SOFT_W-1:0] wr_soft_i,
    input  logic signed [SOFT_W-1:0] wr_soft_q,
    input  logic                     pop,
    output logic                     rd_valid,
    output logic                     rd_last,
    output logic signed [SOFT_W-1:0] rd_soft_i,
    output logic signed [SOFT_W-1:0] rd_soft_q
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int ENT_W = 2 * SOFT_W + 1;

    logic [ENT_W-1:0] entry_reg [0:FIFO_DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [ENT_W-1:0] head;
    logic             do_pop;

    assign do_pop     = pop && (count_reg != '0);
    assign count_next = count_reg + CNT_W'(wr.valid) - CNT_W'(do_pop);

    always_ff @(posedge clk)
    begin
        if (wr.valid)
        begin
            entry_reg[wr_ptr_reg] <= {wr.last, wr_soft_i, wr_soft_q};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    assign head      = entry_reg[rd_ptr_reg];
    assign rd_valid  = (count_reg != '0);
    assign rd_last   = head[ENT_W-1];
    assign rd_soft_i = head[2*SOFT_W-1:SOFT_W];
    assign rd_soft_q = head[SOFT_W-1:0];

endmodule

`default_nettype wire

// ===== src/dqcd_unit.sv =====
// Top level of the DQPSK carrier demodulator: phase memory, differential
// product, squaring, soft slicer and output FIFO. Depends on dqcd_pkg and all submodules.
//
// Usage: bins enter on the input channel (in_valid/in_ready) with kind, bin_re,
// bin_im, bin_index and last. A reference bin is written into the phase memory
// and gives no result. A data bin is multiplied by the conjugate of the stored
// bin, replaces it, and yields one transaction on the output channel
// (out_valid/out_ready) with soft_i, soft_q and last_res.
// Throughput is one bin per cycle while in_ready is high; each bin takes one
// read-before-write access to the single-port phase memory, so bins to the
// same index may follow each other directly. From input to output a data bin
// passes the multipliers, the squarers and the seven-stage bitwise slicer pipeline.
// The datapath never stalls. A credit counter admits a data bin only while the
// 16-entry output FIFO has a place reserved for it; if the receiver stalls,
// results collect in the FIFO and in_ready falls once all places are taken.
// Reset clears the pipeline, FIFO and credits; the phase memory is not cleared,
// and every bin must be preceded by a reference bin at the same index.
`default_nettype none

module dqpsk_carrier_demodulator_unit import dqcd_pkg::*; #(
    parameter int FFT_SIZE     = 2048,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     kind,
    input  logic signed [15:0]       bin_re,
    input  logic signed [15:0]       bin_im,
    input  logic [10:0]              bin_index,
    input  logic                     last,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [SOFT_W-1:0] soft_i,
    output logic signed [SOFT_W-1:0] soft_q,
    output logic                     last_res
);

    localparam int ADDR_W = $clog2(FFT_SIZE);
    localparam int SHIFT  = (SAMPLE_WIDTH >= SAMP_W) ? 0 : SAMP_W - SAMPLE_WIDTH;
    localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);

    logic                     accept;
    logic                     pop;
    logic signed [SAMP_W-1:0] re_ext;
    logic signed [SAMP_W-1:0] im_ext;
    logic [2*SAMP_W-1:0]      old_word;
    logic signed [SAMP_W-1:0] pre;
    logic signed [SAMP_W-1:0] pim;

    logic                     s1_valid_reg;
    logic                     s1_last_reg;
    logic signed [SAMP_W-1:0] s1_re_reg;
    logic signed [SAMP_W-1:0] s1_im_reg;

    logic                     s2_valid_reg;
    logic                     s2_last_reg;
    logic signed [PROD_W-1:0] rre_reg;
    logic signed [PROD_W-1:0] rim_reg;
    logic signed [PROD_W-1:0] rre_next;
    logic signed [PROD_W-1:0] rim_next;

    logic [PROD_W-1:0]        abs_i;
    logic [PROD_W-1:0]        abs_q;
    logic [MAG_W-1:0]         mag_i;
    logic [MAG_W-1:0]         mag_q;
    logic [SQ_W-1:0]          sq_i_reg;
    logic [SQ_W-1:0]          sq_q_reg;
    slice_ctrl_t              s3_ctrl_reg;
    slice_ctrl_t              s3_ctrl_next;

    res_ctrl_t                res;
    logic signed [SOFT_W-1:0] res_soft_i;
    logic signed [SOFT_W-1:0] res_soft_q;

    logic [CNT_W-1:0]         credit_reg;
    logic [CNT_W-1:0]         credit_next;

    assign accept = in_valid && in_ready;
    assign pop    = out_valid && out_ready;

    always_comb
    begin
        re_ext = (bin_re <<< SHIFT) >>> SHIFT;
        im_ext = (bin_im <<< SHIFT) >>> SHIFT;
    end

    dqcd_phase_mem #(
        .DEPTH  (FFT_SIZE),
        .ADDR_W (ADDR_W),
        .DATA_W (2 * SAMP_W)
    ) u_phase_mem (
        .clk   (clk),
        .en    (accept),
        .addr  (bin_index[ADDR_W-1:0]),
        .wdata ({im_ext, re_ext}),
        .rdata (old_word)
    );

    assign pre = old_word[SAMP_W-1:0];
    assign pim = old_word[2*SAMP_W-1:SAMP_W];

    assign rre_next = PROD_W'(s1_re_reg * pre) + PROD_W'(s1_im_reg * pim);
    assign rim_next = PROD_W'(s1_im_reg * pre) - PROD_W'(s1_re_reg * pim);

    assign abs_i = rre_reg[PROD_W-1] ? PROD_W'(-rre_reg) : PROD_W'(rre_reg);
    assign abs_q = rim_reg[PROD_W-1] ? PROD_W'(-rim_reg) : PROD_W'(rim_reg);
    assign mag_i = abs_i[MAG_W-1:0];
    assign mag_q = abs_q[MAG_W-1:0];

    always_comb
    begin
        s3_ctrl_next.valid  = s2_valid_reg;
        s3_ctrl_next.last   = s2_last_reg;
        s3_ctrl_next.zero_i = (rre_reg == '0);
        s3_ctrl_next.neg_i  = !rre_reg[PROD_W-1] && (rre_reg != '0);
        s3_ctrl_next.zero_q = (rim_reg == '0);
        s3_ctrl_next.neg_q  = !rim_reg[PROD_W-1] && (rim_reg != '0);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_last_reg <= last;
            s1_re_reg   <= re_ext;
            s1_im_reg   <= im_ext;
        end
        s2_last_reg <= s1_last_reg;
        rre_reg     <= rre_next;
        rim_reg     <= rim_next;
        sq_i_reg    <= SQ_W'(mag_i) * SQ_W'(mag_i);
        sq_q_reg    <= SQ_W'(mag_q) * SQ_W'(mag_q);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_ctrl_reg  <= '0;
            credit_reg   <= '0;
        end
        else
        begin
            s1_valid_reg <= accept && (kind == KIND_DATA);
            s2_valid_reg <= s1_valid_reg;
            s3_ctrl_reg  <= s3_ctrl_next;
            credit_reg   <= credit_next;
        end
    end

    dqcd_soft_slicer u_slicer (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (s3_ctrl_reg),
        .sq_i   (sq_i_reg),
        .sq_q   (sq_q_reg),
        .res    (res),
        .soft_i (res_soft_i),
        .soft_q (res_soft_q)
    );

    dqcd_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (res),
        .wr_soft_i (res_soft_i),
        .wr_soft_q (res_soft_q),
        .pop       (pop),
        .rd_valid  (out_valid),
        .rd_last   (last_res),
        .rd_soft_i (soft_i),
        .rd_soft_q (soft_q)
    );

    assign credit_next = credit_reg + CNT_W'(accept && (kind == KIND_DATA)) - CNT_W'(pop);
    assign in_ready    = (credit_reg < CNT_W'(FIFO_DEPTH));

    // A data transaction holds one credit from acceptance until its result leaves.
    a_credit_bound : assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg <= CNT_W'(FIFO_DEPTH))
        else $error("credit count above FIFO depth");

    a_out_has_credit : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (credit_reg != '0))
        else $error("result present without a held credit");

    a_ref_no_credit : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (kind == KIND_REF) && !pop) |=> (credit_reg == $past(credit_reg)))
        else $error("reference transaction changed the credit count");

    a_data_reaches_slicer : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (kind == KIND_DATA)) |=> ##2 s3_ctrl_reg.valid)
        else $error("data transaction lost before the slicer");

endmodule

`default_nettype wire

// ===== verif/dqpsk_carrier_demodulator_unit_tb.sv =====
// Self-checking testbench for the DQPSK carrier demodulator top level.
// Drives reference and data bins, predicts the soft bits in place, compares results.
// Depends on dqcd_pkg and dqpsk_carrier_demodulator_unit.
`timescale 1ns / 100ps

module dqpsk_carrier_demodulator_unit_tb import dqcd_pkg::*;;

    typedef struct packed {
        logic        kind;
        logic [15:0] re;
        logic [15:0] im;
        logic [10:0] idx;
        logic        last;
    } bin_t;

    typedef struct packed {
        logic [7:0] si;
        logic [7:0] sq;
        logic       last;
    } soft_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic kind;
    logic signed [15:0] bin_re;
    logic signed [15:0] bin_im;
    logic [10:0] bin_index;
    logic last;
    logic out_valid;
    logic out_ready;
    logic signed [7:0] soft_i;
    logic signed [7:0] soft_q;
    logic last_res;
    logic in_ready_seen;

    bin_t pending_bins[$];
    soft_t expected_soft[$];
    logic [31:0] carrier_phase [0:2047];
    bit written [0:2047];
    int errors;
    int gap_left;
    int stall_left;
    int hold_off;
    bit stim_done;

    dqpsk_carrier_demodulator_unit u_top (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .bin_re(bin_re), .bin_im(bin_im), .bin_index(bin_index),
        .last(last), .out_valid(out_valid), .out_ready(out_ready),
        .soft_i(soft_i), .soft_q(soft_q), .last_res(last_res)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int short_or_long_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 3);
    endfunction

    function automatic logic [7:0] soft_slice(longint c, longint o);
        longint unsigned ac;
        longint unsigned oo;
        longint unsigned cc;
        longint unsigned q;
        logic [127:0] lhs;
        logic [127:0] rhs;
        ac = (c < 0) ? -c : c;
        cc = ac * ac;
        oo = (o < 0) ? (-o) * (-o) : o * o;
        if (ac == 0)
            return 8'd0;
        q = 127;
        forever
        begin
            lhs = 128'(q * q) * 128'(oo);
            rhs = 128'(16129 - q * q) * 128'(cc);
            if (q == 0 || lhs <= rhs)
                break;
            q--;
        end
        return (c > 0) ? 8'(-q) : 8'(q);
    endfunction

    task automatic predict_bin(input bin_t b);
        longint dre;
        longint dim;
        longint pre;
        longint pim;
        longint rre;
        longint rim;
        soft_t s;
        dre = longint'($signed(b.re));
        dim = longint'($signed(b.im));
        if (b.kind == KIND_DATA)
        begin
            pre = longint'($signed(carrier_phase[b.idx][15:0]));
            pim = longint'($signed(carrier_phase[b.idx][31:16]));
            rre = dre * pre + dim * pim;
            rim = dim * pre - dre * pim;
            s.si = soft_slice(rre, rim);
            s.sq = soft_slice(rim, rre);
            s.last = b.last;
            expected_soft.push_back(s);
        end
        carrier_phase[b.idx] = {b.im, b.re};
        written[b.idx] = 1'b1;
    endtask

    task automatic add_bin(input logic k, input logic [15:0] re, input logic [15:0] im,
                           input logic [10:0] idx, input logic l);
        bin_t b;
        b = '{kind: k, re: re, im: im, idx: idx, last: l};
        if (k == KIND_DATA && !written[idx])
            b.kind = KIND_REF;
        predict_bin(b);
        pending_bins.push_back(b);
    endtask

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'(int'($urandom_range(0, 8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        int base;
        int n;
        errors = 0;
        stim_done = 1'b0;
        for (int i = 0; i < 2048; i++)
            written[i] = 1'b0;
        add_bin(KIND_REF, 16'h7fff, 16'h0000, 11'd0, 1'b1);
        add_bin(KIND_DATA, 16'h7fff, 16'h0000, 11'd0, 1'b0);
        add_bin(KIND_DATA, 16'h0000, 16'h7fff, 11'd0, 1'b1);
        add_bin(KIND_DATA, 16'h8000, 16'h8000, 11'd0, 1'b0);
        add_bin(KIND_DATA, 16'h7fff, 16'h8000, 11'd0, 1'b1);
        add_bin(KIND_DATA, 16'h0000, 16'h0000, 11'd0, 1'b0);
        add_bin(KIND_DATA, 16'h1234, 16'hfedc, 11'd0, 1'b0);
        add_bin(KIND_REF, 16'h8000, 16'h7fff, 11'd2047, 1'b1);
        add_bin(KIND_DATA, 16'h8000, 16'h8000, 11'd2047, 1'b1);
        add_bin(KIND_DATA, 16'hffff, 16'h0001, 11'd2047, 1'b0);
        add_bin(KIND_DATA, 16'h0003, 16'h0004, 11'd2047, 1'b0);
        add_bin(KIND_REF, 16'h0001, 16'h0001, 11'd1024, 1'b0);
        add_bin(KIND_DATA, 16'h0001, 16'hffff, 11'd1024, 1'b1);
        add_bin(KIND_DATA, 16'h5555, 16'haaaa, 11'd1024, 1'b0);
        add_bin(KIND_DATA, 16'haaaa, 16'h5555, 11'd1024, 1'b1);
        add_bin(KIND_DATA, 16'h0000, 16'h0000, 11'd2047, 1'b0);
        while (pending_bins.size() < 1600)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                add_bin(logic'($urandom_range(0, 1)), rand_comp(), rand_comp(),
                        11'($urandom), logic'($urandom_range(0, 1)));
            end
            else
            begin
                base = $urandom_range(0, 2047);
                n = $urandom_range(2, 24);
                for (int c = 0; c < n; c++)
                    add_bin(KIND_REF, rand_comp(), rand_comp(), 11'((base + c) % 2048),
                            logic'(c == n - 1));
                for (int s = 0; s < $urandom_range(1, 4); s++)
                    for (int c = 0; c < n; c++)
                        add_bin(KIND_DATA, rand_comp(), rand_comp(),
                                11'((base + c) % 2048), logic'(c == n - 1));
            end
        end
        stim_done = 1'b1;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Driver: an item stays on the ports until it is taken.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            kind <= KIND_REF;
            bin_re <= '0;
            bin_im <= '0;
            bin_index <= '0;
            last <= 1'b0;
            gap_left <= 0;
        end
        else if (!in_valid || in_ready_seen)
        begin
            if (gap_left > 0 || pending_bins.size() == 0 || !stim_done)
            begin
                in_valid <= 1'b0;
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
            end
            else
            begin
                bin_t b;
                b = pending_bins.pop_front();
                in_valid <= 1'b1;
                kind <= b.kind;
                bin_re <= b.re;
                bin_im <= b.im;
                bin_index <= b.idx;
                last <= b.last;
                gap_left <= short_or_long_gap();
            end
        end
    end

    always @(posedge clk)
        in_ready_seen <= in_valid && in_ready;

    // Receiver: random stalls, with one long hold-off early in the run.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left <= 0;
            hold_off <= 300;
        end
        else if (hold_off > 0 && pending_bins.size() < 1500 && stim_done)
        begin
            out_ready <= 1'b0;
            hold_off <= hold_off - 1;
        end
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left <= short_or_long_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_soft.size() == 0)
            begin
                $display("%0t: unexpected result soft_i=%0d soft_q=%0d last=%0b",
                         $time, soft_i, soft_q, last_res);
                errors++;
            end
            else
            begin
                soft_t e;
                e = expected_soft.pop_front();
                if (soft_i !== e.si || soft_q !== e.sq || last_res !== e.last)
                begin
                    $display("%0t: expected i=%0d q=%0d last=%0b, got i=%0d q=%0d last=%0b",
                             $time, $signed(e.si), $signed(e.sq), e.last,
                             soft_i, soft_q, last_res);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        wait (stim_done);
        wait (pending_bins.size() == 0 && !in_valid);
        wait (expected_soft.size() == 0);
        repeat (40) @(posedge clk);
        if (errors == 0 && expected_soft.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
src/dqcd_pkg.sv
src/dqcd_phase_mem.sv
src/dqcd_soft_slicer.sv
src/dqcd_out_fifo.sv
src/dqcd_unit.sv
verif/dqpsk_carrier_demodulator_unit_tb.sv
